@@ rtl/sprmv_pkg.sv @@
// Shared types, codes and shape tables for the sprite mover.
// No dependencies; every other rtl file imports this package.
package sprmv_pkg;

  // Coordinate widths: registers are 12 bits, working coordinates are signed
  localparam int COORD_W = 12;
  localparam int SW      = 15;
  localparam int VEL_W   = 5;
  localparam int VEL_MAX = 15;

  // Outline of the sprite: widths, heights and top offsets of each row box
  localparam int SHAPE_ROWS = 11;
  localparam int SHAPE_W   [SHAPE_ROWS] = '{6, 10, 14, 16, 18, 20, 18, 16, 14, 10, 6};
  localparam int SHAPE_H   [SHAPE_ROWS] = '{1, 1, 1, 2, 2, 6, 2, 2, 1, 1, 1};
  localparam int SHAPE_TOP [SHAPE_ROWS] = '{0, 1, 2, 3, 5, 7, 13, 15, 17, 18, 19};

  // Reset values of the configuration registers
  localparam logic [COORD_W-1:0] RST_OTHER_X  = 12'd20;
  localparam logic [COORD_W-1:0] RST_OTHER_Y  = 12'd20;
  localparam logic [COORD_W-1:0] RST_SCREEN_W = 12'd640;
  localparam logic [COORD_W-1:0] RST_SCREEN_H = 12'd480;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3
  } dir_e;

  typedef enum logic [1:0] {
    CFG_OTHER_X  = 2'd0,
    CFG_OTHER_Y  = 2'd1,
    CFG_SCREEN_W = 2'd2,
    CFG_SCREEN_H = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] other_x;
    logic [COORD_W-1:0] other_y;
    logic [COORD_W-1:0] screen_w;
    logic [COORD_W-1:0] screen_h;
  } cfg_t;

  typedef struct packed {
    logic        [COORD_W-1:0] x;
    logic        [COORD_W-1:0] y;
    logic signed [VEL_W-1:0]   vx;
    logic signed [VEL_W-1:0]   vy;
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               blocked_x;
    logic               blocked_y;
  } result_t;

  // Step a velocity by one towards plus or minus, saturating at the limit
  function automatic logic signed [VEL_W-1:0] vel_step(input logic signed [VEL_W-1:0] v,
                                                       input logic up);
    logic signed [VEL_W-1:0] r;
    r = v;
    if (up && (v != VEL_W'(VEL_MAX))) begin
      r = v + VEL_W'(1);
    end else if (!up && (v != -VEL_W'(VEL_MAX))) begin
      r = v - VEL_W'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/sprite_move_box_collision.sv @@
// Sprite mover with box-set collision against a fixed obstacle sprite.
// Depends on sprmv_pkg, sprmv_cfg, sprmv_step (and through it sprmv_hit).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: mode_i and
//   direction_i. Key press and release change the x or y velocity by one,
//   saturating at plus or minus 15; a frame tick moves x, then y, reverting
//   an axis that would leave the screen or overlap the obstacle outline.
//   Output channel (out_valid_o / out_stall_i) returns one result per
//   request: position after the request and the two blocked flags.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes obstacle
//   position and screen size by index; write it only while the block is idle.
// Timing:
//   A request accepted into the input register is processed in one pass
//   through the box-pair compare grid, and its result is then captured in
//   the result register; one request per cycle is sustained while
//   out_stall_i is low. The box-pair compare grid in that pass sets the cycle.
// Reset:
//   Position and velocities clear to zero, the registers take their defaults
//   and both channels come up empty. While out_stall_i is high the result
//   holds; one more request may wait in the input register, then
//   in_stall_o rises.
module sprite_move_box_collision #(
  parameter int NUM_BOXES   = 11,
  parameter int SPRITE_SIZE = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [2:0]                     direction_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sprmv_pkg::COORD_W-1:0]  pos_x_o,
  output logic [sprmv_pkg::COORD_W-1:0]  pos_y_o,
  output logic                           blocked_x_o,
  output logic                           blocked_y_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [sprmv_pkg::COORD_W-1:0]  cfg_data_i
);
  import sprmv_pkg::*;

  cfg_t       cfg;
  state_t     state_q, state_d;
  result_t    res_q, res_d;
  logic       in_valid_q, out_valid_q;
  logic [1:0] mode_q;
  logic [2:0] dir_q;
  logic       out_free, advance, in_take;

  // Configuration registers
  sprmv_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: advance the held request when the result register is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || out_free) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= mode_i;
      dir_q  <= direction_i;
    end
  end

  // Single pass over the held request
  sprmv_step #(.NUM_BOXES(NUM_BOXES), .SPRITE_SIZE(SPRITE_SIZE)) u_step (
    .mode_i     (mode_q),
    .direction_i(dir_q),
    .state_i    (state_q),
    .cfg_i      (cfg),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  // Sprite state: commit when the request moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = res_q.pos_x;
  assign pos_y_o     = res_q.pos_y;
  assign blocked_x_o = res_q.blocked_x;
  assign blocked_y_o = res_q.blocked_y;

  // Non-tick requests leave the position alone and report no blocking
  a_key_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (mode_e'(mode_q) != MODE_TICK) |=>
      $stable(state_q.x) && $stable(state_q.y) && !res_q.blocked_x && !res_q.blocked_y)
    else $error("non-tick request moved the sprite or flagged blocking");

  // Velocities never leave the saturation range
  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.vx != -VEL_W'(16)) && (state_q.vy != -VEL_W'(16)))
    else $error("velocity outside saturation range");

  // A tick never changes the velocities
  a_tick_keeps_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (mode_e'(mode_q) == MODE_TICK) |=> $stable(state_q.vx) && $stable(state_q.vy))
    else $error("tick changed a velocity");

  // An accepted horizontal move keeps the sprite on screen
  a_x_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (mode_e'(mode_q) == MODE_TICK) && !res_d.blocked_x |=>
      (({3'b000, state_q.x} + 15'(SPRITE_SIZE)) <= {3'b000, cfg.screen_w}))
    else $error("unblocked horizontal move left the screen");

  // The result reports the committed position
  a_result_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_q.pos_x == state_q.x) && (res_q.pos_y == state_q.y))
    else $error("result position differs from sprite state");

endmodule

@@ rtl/sprmv_cfg.sv @@
// Configuration register file: obstacle position and screen limits.
// Depends on sprmv_pkg.
module sprmv_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [sprmv_pkg::COORD_W-1:0]  cfg_data_i,
  output sprmv_pkg::cfg_t                cfg_o
);
  import sprmv_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always ready: a write lands in its register in the next cycle
  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OTHER_X:  cfg_d.other_x  = cfg_data_i;
        CFG_OTHER_Y:  cfg_d.other_y  = cfg_data_i;
        CFG_SCREEN_W: cfg_d.screen_w = cfg_data_i;
        CFG_SCREEN_H: cfg_d.screen_h = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.other_x  <= RST_OTHER_X;
      cfg_q.other_y  <= RST_OTHER_Y;
      cfg_q.screen_w <= RST_SCREEN_W;
      cfg_q.screen_h <= RST_SCREEN_H;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/sprmv_hit.sv @@
// Box-set overlap test between the moving sprite and the obstacle sprite.
// Depends on sprmv_pkg (shape tables, coordinate widths).
module sprmv_hit #(
  parameter int NUM_BOXES   = 11,
  parameter int SPRITE_SIZE = 20
) (
  input  logic signed [sprmv_pkg::SW-1:0]      ax_i,
  input  logic signed [sprmv_pkg::SW-1:0]      ay_i,
  input  logic        [sprmv_pkg::COORD_W-1:0] bx_i,
  input  logic        [sprmv_pkg::COORD_W-1:0] by_i,
  output logic                                 hit_o
);
  import sprmv_pkg::*;

  localparam int NB = (NUM_BOXES < SHAPE_ROWS) ? NUM_BOXES : SHAPE_ROWS;

  logic signed [SW-1:0] dx, dy;
  logic [NB*NB-1:0]     pair_hit;

  // Relative offset of the two sprites; every box test is a compare on it
  assign dx = ax_i - $signed({{(SW-COORD_W){1'b0}}, bx_i});
  assign dy = ay_i - $signed({{(SW-COORD_W){1'b0}}, by_i});

  // Box i of the sprite against box j of the obstacle: open-interval overlap
  for (genvar i = 0; i < NB; i++) begin : g_a
    for (genvar j = 0; j < NB; j++) begin : g_b
      localparam int OFF_I = (SPRITE_SIZE - SHAPE_W[i]) / 2;
      localparam int OFF_J = (SPRITE_SIZE - SHAPE_W[j]) / 2;
      localparam int X_HI  = OFF_J + SHAPE_W[j] - OFF_I;
      localparam int X_LO  = OFF_J - OFF_I - SHAPE_W[i];
      localparam int Y_HI  = SHAPE_TOP[j] + SHAPE_H[j] - SHAPE_TOP[i];
      localparam int Y_LO  = SHAPE_TOP[j] - SHAPE_TOP[i] - SHAPE_H[i];
      assign pair_hit[i*NB+j] = (dx < SW'(X_HI)) && (dx > SW'(X_LO)) &&
                                (dy < SW'(Y_HI)) && (dy > SW'(Y_LO));
    end
  end

  assign hit_o = |pair_hit;

endmodule

@@ rtl/sprmv_step.sv @@
// Next-state logic for one request: velocity keys and the two-axis move.
// Depends on sprmv_pkg and sprmv_hit.
module sprmv_step #(
  parameter int NUM_BOXES   = 11,
  parameter int SPRITE_SIZE = 20
) (
  input  logic [1:0]          mode_i,
  input  logic [2:0]          direction_i,
  input  sprmv_pkg::state_t   state_i,
  input  sprmv_pkg::cfg_t     cfg_i,
  output sprmv_pkg::state_t   state_o,
  output sprmv_pkg::result_t  result_o
);
  import sprmv_pkg::*;

  logic signed [SW-1:0] cur_x, cur_y, nx, ny;
  logic signed [SW-1:0] lim_w, lim_h;
  logic                 fit_x, fit_y;
  logic                 hit_x, hit_y_old, hit_y_new, hit_y;
  logic                 blk_x, blk_y;
  logic                 is_key, vel_up;
  logic [COORD_W-1:0]   x_moved, y_moved;

  assign cur_x = $signed({{(SW-COORD_W){1'b0}}, state_i.x});
  assign cur_y = $signed({{(SW-COORD_W){1'b0}}, state_i.y});
  assign lim_w = $signed({{(SW-COORD_W){1'b0}}, cfg_i.screen_w});
  assign lim_h = $signed({{(SW-COORD_W){1'b0}}, cfg_i.screen_h});

  // Candidate positions
  assign nx = cur_x + SW'(state_i.vx);
  assign ny = cur_y + SW'(state_i.vy);

  // Screen limits
  assign fit_x = (nx >= 0) && ((nx + SW'(SPRITE_SIZE)) <= lim_w);
  assign fit_y = (ny >= 0) && ((ny + SW'(SPRITE_SIZE)) <= lim_h);

  // Horizontal move tested at the old row
  sprmv_hit #(.NUM_BOXES(NUM_BOXES), .SPRITE_SIZE(SPRITE_SIZE)) u_hit_x (
    .ax_i (nx),
    .ay_i (cur_y),
    .bx_i (cfg_i.other_x),
    .by_i (cfg_i.other_y),
    .hit_o(hit_x)
  );

  // Vertical move tested at both possible columns, picked once x settles
  sprmv_hit #(.NUM_BOXES(NUM_BOXES), .SPRITE_SIZE(SPRITE_SIZE)) u_hit_y_old (
    .ax_i (cur_x),
    .ay_i (ny),
    .bx_i (cfg_i.other_x),
    .by_i (cfg_i.other_y),
    .hit_o(hit_y_old)
  );

  sprmv_hit #(.NUM_BOXES(NUM_BOXES), .SPRITE_SIZE(SPRITE_SIZE)) u_hit_y_new (
    .ax_i (nx),
    .ay_i (ny),
    .bx_i (cfg_i.other_x),
    .by_i (cfg_i.other_y),
    .hit_o(hit_y_new)
  );

  assign blk_x   = !fit_x || hit_x;
  assign hit_y   = blk_x ? hit_y_old : hit_y_new;
  assign blk_y   = !fit_y || hit_y;
  assign x_moved = blk_x ? state_i.x : nx[COORD_W-1:0];
  assign y_moved = blk_y ? state_i.y : ny[COORD_W-1:0];

  // Key direction: down and right raise, a release inverts
  assign is_key = (mode_e'(mode_i) == MODE_PRESS) || (mode_e'(mode_i) == MODE_RELEASE);
  assign vel_up = ((dir_e'(direction_i) == DIR_DOWN) || (dir_e'(direction_i) == DIR_RIGHT))
                  ^ (mode_e'(mode_i) == MODE_RELEASE);

  // Apply the request
  always_comb begin
    state_o            = state_i;
    result_o.blocked_x = 1'b0;
    result_o.blocked_y = 1'b0;
    if (is_key) begin
      case (dir_e'(direction_i))
        DIR_UP, DIR_DOWN:    state_o.vy = vel_step(state_i.vy, vel_up);
        DIR_LEFT, DIR_RIGHT: state_o.vx = vel_step(state_i.vx, vel_up);
        default:             state_o = state_i;
      endcase
    end else if (mode_e'(mode_i) == MODE_TICK) begin
      state_o.x          = x_moved;
      state_o.y          = y_moved;
      result_o.blocked_x = blk_x;
      result_o.blocked_y = blk_y;
    end
    result_o.pos_x = state_o.x;
    result_o.pos_y = state_o.y;
  end

endmodule

@@ tb/sprite_move_box_collision_tb.sv @@
// Self-checking testbench for sprite_move_box_collision: key and tick requests
// are checked against a predictor of position, velocity and box collisions.
// Depends on sprmv_pkg and the sprite_move_box_collision RTL.
`timescale 1ns / 100ps

module sprite_move_box_collision_tb;
  import sprmv_pkg::*;

  localparam int          SPRITE_PX      = 20;
  localparam int          OUTLINE_ROWS   = 11;
  localparam int          VEL_LIMIT      = 15;
  localparam int          IDLE_PCT       = 36;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [2:0]  DIR_SPARE_LO   = 3'd4;
  localparam logic [2:0]  DIR_SPARE_HI   = 3'd7;
  localparam int          OUTLINE_W [OUTLINE_ROWS] = '{6, 10, 14, 16, 18, 20, 18, 16, 14, 10, 6};
  localparam int          OUTLINE_H [OUTLINE_ROWS] = '{1, 1, 1, 2, 2, 6, 2, 2, 1, 1, 1};

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i      = MODE_NONE;
  logic [2:0]         direction_i = DIR_UP;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [COORD_W-1:0] pos_x_o;
  logic [COORD_W-1:0] pos_y_o;
  logic               blocked_x_o;
  logic               blocked_y_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_OTHER_X;
  logic [COORD_W-1:0] cfg_data_i  = '0;

  // Predicted sprite state and register copies
  int model_x, model_y, model_vx, model_vy;
  int obst_x, obst_y, scr_w, scr_h;

  result_t pending_positions[$];
  int      mismatches    = 0;
  int      results_seen  = 0;
  int      quiet_cycles  = 0;
  bit      calm_q        = 1'b0;

  sprite_move_box_collision i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .direction_i(direction_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .blocked_x_o(blocked_x_o),
    .blocked_y_o(blocked_y_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock: 10 ns period
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Clamp a velocity to the symmetric limit
  function automatic int clamp_vel(input int v);
    if (v > VEL_LIMIT) return VEL_LIMIT;
    if (v < -VEL_LIMIT) return -VEL_LIMIT;
    return v;
  endfunction

  // True if the sprite placed at (ax, ay) overlaps any box of the obstacle
  function automatic bit sprite_overlaps(input int ax, input int ay);
    int top_a, top_b, la, lb;
    bit hit;
    hit   = 1'b0;
    top_a = ay;
    for (int i = 0; i < OUTLINE_ROWS; i++) begin
      la    = ax + (SPRITE_PX - OUTLINE_W[i]) / 2;
      top_b = obst_y;
      for (int j = 0; j < OUTLINE_ROWS; j++) begin
        lb = obst_x + (SPRITE_PX - OUTLINE_W[j]) / 2;
        // Touching edges leave zero area, so only strict overlap counts
        if (top_a < top_b + OUTLINE_H[j] && top_b < top_a + OUTLINE_H[i] &&
            la < lb + OUTLINE_W[j] && lb < la + OUTLINE_W[i]) begin
          hit = 1'b1;
        end
        top_b += OUTLINE_H[j];
      end
      top_a += OUTLINE_H[i];
    end
    return hit;
  endfunction

  // Advance the predicted state by one request and return the expected result
  function automatic result_t predict_move(input logic [1:0] mode, input logic [2:0] dir);
    result_t r;
    int      delta, nx, ny;
    r = '0;
    if (mode == MODE_PRESS || mode == MODE_RELEASE) begin
      delta = (mode == MODE_PRESS) ? 1 : -1;
      case (dir)
        DIR_UP:    model_vy = clamp_vel(model_vy - delta);
        DIR_DOWN:  model_vy = clamp_vel(model_vy + delta);
        DIR_LEFT:  model_vx = clamp_vel(model_vx - delta);
        DIR_RIGHT: model_vx = clamp_vel(model_vx + delta);
        default: ;
      endcase
    end else if (mode == MODE_TICK) begin
      // Try x first, then y from the settled x
      nx = model_x + model_vx;
      if (nx < 0 || nx + SPRITE_PX > scr_w || sprite_overlaps(nx, model_y)) begin
        r.blocked_x = 1'b1;
      end else begin
        model_x = nx;
      end
      ny = model_y + model_vy;
      if (ny < 0 || ny + SPRITE_PX > scr_h || sprite_overlaps(model_x, ny)) begin
        r.blocked_y = 1'b1;
      end else begin
        model_y = ny;
      end
    end
    r.pos_x = COORD_W'(model_x);
    r.pos_y = COORD_W'(model_y);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch in %s of result %0d: got %0d, expected %0d",
             field, results_seen, got, want);
    mismatches++;
  endtask

  // Send one request, idling at random beforehand outside calm stretches, and record its expectation
  task automatic send_request(input logic [1:0] mode, input logic [2:0] dir);
    while (!calm_q && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    direction_i <= dir;
    do @(posedge clk_i); while (in_stall_o);
    pending_positions.push_back(predict_move(mode, dir));
  endtask

  // Hold off the sender until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_positions.size() != 0);
  endtask

  // Write one register; call only while the block is idle
  task automatic write_register(input cfg_idx_e idx, input logic [COORD_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_OTHER_X:  obst_x = value;
      CFG_OTHER_Y:  obst_y = value;
      CFG_SCREEN_W: scr_w  = value;
      CFG_SCREEN_H: scr_h  = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                           input logic [COORD_W-1:0] sw, input logic [COORD_W-1:0] sh);
    drain_results();
    write_register(CFG_OTHER_X, ox);
    write_register(CFG_OTHER_Y, oy);
    write_register(CFG_SCREEN_W, sw);
    write_register(CFG_SCREEN_H, sh);
  endtask

  // Random requests: press_pct of presses, 12 percent releases, ticks up to 95 percent, the rest spare mode
  task automatic random_burst(input int count, input int press_pct,
                              input dir_e bias_dir, input int bias_pct);
    int         r;
    logic [1:0] mode;
    logic [2:0] dir;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < press_pct)           mode = MODE_PRESS;
      else if (r < press_pct + 12) mode = MODE_RELEASE;
      else if (r < 95)             mode = MODE_TICK;
      else                         mode = MODE_NONE;
      if ($urandom_range(0, 99) < 8) begin
        dir = 3'($urandom_range(DIR_SPARE_LO, DIR_SPARE_HI));
      end else if ($urandom_range(0, 99) < bias_pct) begin
        dir = bias_dir;
      end else begin
        dir = 3'($urandom_range(DIR_UP, DIR_RIGHT));
      end
      send_request(mode, dir);
    end
  endtask

  // Park the obstacle off the play area, then steer the sprite back to the
  // top-left corner without overshooting
  task automatic home_sprite();
    int tx, ty;
    configure(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    while (model_x != 0 || model_y != 0) begin
      tx = (model_x < VEL_LIMIT) ? -model_x : -VEL_LIMIT;
      ty = (model_y < VEL_LIMIT) ? -model_y : -VEL_LIMIT;
      while (model_vx < tx) send_request(MODE_PRESS, DIR_RIGHT);
      while (model_vx > tx) send_request(MODE_PRESS, DIR_LEFT);
      while (model_vy < ty) send_request(MODE_PRESS, DIR_DOWN);
      while (model_vy > ty) send_request(MODE_PRESS, DIR_UP);
      send_request(MODE_TICK, DIR_UP);
    end
  endtask

  // Reset state: zero-velocity tick, ignored keys and the spare mode
  task automatic test_reset_state();
    send_request(MODE_TICK, DIR_UP);
    send_request(MODE_NONE, DIR_SPARE_HI);
    send_request(MODE_PRESS, DIR_SPARE_LO);
    send_request(MODE_RELEASE, 3'd5);
    send_request(MODE_PRESS, 3'd6);
    send_request(MODE_RELEASE, DIR_SPARE_HI);
    send_request(MODE_TICK, DIR_SPARE_HI);
  endtask

  // Every key pressed and released, then moves off the top-left edges
  task automatic test_key_directions();
    send_request(MODE_PRESS, DIR_UP);
    send_request(MODE_PRESS, DIR_DOWN);
    send_request(MODE_PRESS, DIR_LEFT);
    send_request(MODE_PRESS, DIR_RIGHT);
    send_request(MODE_RELEASE, DIR_UP);
    send_request(MODE_RELEASE, DIR_DOWN);
    send_request(MODE_RELEASE, DIR_LEFT);
    send_request(MODE_RELEASE, DIR_RIGHT);
    send_request(MODE_PRESS, DIR_LEFT);
    send_request(MODE_PRESS, DIR_UP);
    send_request(MODE_TICK, DIR_DOWN);
    send_request(MODE_RELEASE, DIR_LEFT);
    send_request(MODE_RELEASE, DIR_UP);
  endtask

  // Obstacle flush against the sprite: touching passes, one pixel more blocks
  task automatic test_touching_edges();
    configure(12'd20, 12'd0, 12'd640, 12'd480);
    send_request(MODE_TICK, DIR_UP);
    send_request(MODE_PRESS, DIR_RIGHT);
    send_request(MODE_TICK, DIR_UP);
    send_request(MODE_RELEASE, DIR_RIGHT);
    send_request(MODE_PRESS, DIR_DOWN);
    send_request(MODE_TICK, DIR_UP);
    send_request(MODE_RELEASE, DIR_DOWN);
  endtask

  // Default-sized screen, obstacle in the way; first part with no idling
  task automatic test_open_screen();
    configure(12'd60, 12'd40, 12'd640, 12'd480);
    calm_q = 1'b1;
    random_burst(100, 30, DIR_RIGHT, 30);
    calm_q = 1'b0;
    random_burst(100, 30, DIR_DOWN, 30);
  endtask

  // Drive each velocity into both limits on the largest screen
  task automatic test_velocity_limits();
    configure(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    random_burst(60, 60, DIR_RIGHT, 90);
    random_burst(60, 60, DIR_DOWN, 90);
    random_burst(80, 60, DIR_LEFT, 90);
    random_burst(80, 60, DIR_UP, 90);
  endtask

  // Small arena around the obstacle: collisions on most ticks
  task automatic test_tight_arena();
    home_sprite();
    configure(12'd22, 12'd22, 12'd64, 12'd64);
    random_burst(200, 30, DIR_RIGHT, 0);
  endtask

  // Screen exactly the sprite size with the obstacle on top, then too small
  task automatic test_minimal_screens();
    home_sprite();
    configure(12'd0, 12'd0, 12'd20, 12'd20);
    random_burst(40, 30, DIR_LEFT, 0);
    configure(12'd0, 12'd4095, 12'd19, 12'd0);
    random_burst(30, 30, DIR_UP, 0);
  endtask

  // Back to a normal screen with the obstacle elsewhere
  task automatic test_wander();
    configure(12'd300, 12'd200, 12'd640, 12'd480);
    random_burst(150, 30, DIR_RIGHT, 0);
  endtask

  // Take the output side into random stalls, with calm stretches
  always @(posedge clk_i) begin
    out_stall_i <= !calm_q && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_positions.size() == 0) begin
        report_mismatch("unexpected result", pos_x_o, -1);
      end else begin
        want = pending_positions.pop_front();
        if (pos_x_o !== want.pos_x) report_mismatch("pos_x", pos_x_o, want.pos_x);
        if (pos_y_o !== want.pos_y) report_mismatch("pos_y", pos_y_o, want.pos_y);
        if (blocked_x_o !== want.blocked_x)
          report_mismatch("blocked_x", blocked_x_o, want.blocked_x);
        if (blocked_y_o !== want.blocked_y)
          report_mismatch("blocked_y", blocked_y_o, want.blocked_y);
      end
      results_seen++;
    end
  end

  // Abort when nothing moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("sprite_move_box_collision regression: fail");
      $finish;
    end
  end

  initial begin
    model_x  = 0;
    model_y  = 0;
    model_vx = 0;
    model_vy = 0;
    obst_x   = RST_OTHER_X;
    obst_y   = RST_OTHER_Y;
    scr_w    = RST_SCREEN_W;
    scr_h    = RST_SCREEN_H;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_key_directions();
    test_touching_edges();
    test_open_screen();
    test_velocity_limits();
    test_tight_arena();
    test_minimal_screens();
    test_wander();

    // Let the last results out, then settle
    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending_positions.size() == 0) begin
      $display("sprite_move_box_collision regression: pass");
    end else begin
      $display("sprite_move_box_collision regression: fail");
    end
    $finish;
  end

endmodule
